// ----- sv/c3x3_pkg.sv -----
// shared types and constants of the 3x3 clamped convolution block
`default_nettype none

package c3x3_pkg;

  localparam int MAX_WIDTH_DEF = 2048;
  localparam int OUT_DEPTH     = 16;
  localparam int SUM_SHIFT     = 4;
  localparam int PIX_MAX       = 255;

  typedef logic [2:0] cfg_idx_t;

  localparam cfg_idx_t CFG_MASK_TOP    = 3'd0;
  localparam cfg_idx_t CFG_MASK_MIDDLE = 3'd1;
  localparam cfg_idx_t CFG_MASK_BOTTOM = 3'd2;
  localparam cfg_idx_t CFG_WIDTH       = 3'd3;
  localparam cfg_idx_t CFG_HEIGHT      = 3'd4;

  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  typedef struct packed {
    logic       func;
    logic [7:0] pixel;
  } in_item_t;

  typedef struct packed {
    logic [7:0] value;
    logic       end_of_row;
    logic       end_of_frame;
  } out_item_t;

endpackage

`default_nettype wire

// ----- sv/conv3x3_clamped_u8.sv -----
// 3x3 convolution with edge replication over a raster pixel stream, top level
//
// usage: pixels of one frame enter on the in_ channel in raster order (func = pixel),
// followed by frame_width drain items (func = drain) that flush the last row.
// each result on the out_ channel is one filtered pixel with row and frame end flags.
// row y of the output comes out while row y+1 streams in.
// mask rows, width and height are written on the cfg_ channel while the block is idle;
// cfg_ready is always high.
// throughput: one item per cycle while in_ready is high; the line memory holds the two
// previous rows as one word per column, read at acceptance and written back in the next
// cycle, with a bypass when consecutive items hit the same column.
// an item at the end of a row gives up to two results; results leave through a 16-entry
// queue, one per cycle, and in_ready drops when the queue plus the items in flight
// could exceed it, so a stalled receiver holds the input side without losing results.
// reset (synchronous, rst_n low) clears counters, queue, pipeline and registers to their
// defaults: masks 0, width 2048, height 1. the line memory needs no clearing.
`default_nettype none

module conv3x3_clamped_u8 #(
  parameter int MAX_WIDTH = c3x3_pkg::MAX_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire c3x3_pkg::in_item_t  in_data,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      c3x3_pkg::out_item_t out_data,
  input  wire logic               cfg_valid,
  output      logic               cfg_ready,
  input  wire c3x3_pkg::cfg_idx_t  cfg_index,
  input  wire logic [23:0]        cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int EW = (WW > 12) ? WW : 12;
  localparam int QA = $clog2(c3x3_pkg::OUT_DEPTH);
  localparam int QC = $clog2(c3x3_pkg::OUT_DEPTH + 1);
  localparam int OW = QC + 2;

  typedef struct packed {
    logic          wr;
    logic          has_row;
    logic          use_older;
    logic          first;
    logic          emit_l;
    logic          emit_r;
    logic          last_row;
    logic          drain;
    logic [7:0]    pixel;
    logic [CW-1:0] addr;
  } s1_t;

  typedef struct packed {
    logic emit_l;
    logic emit_r;
    logic last_row;
  } emit_t;

  // configuration
  logic [23:0] mask_r [3];
  logic [11:0] width_r;
  logic [15:0] height_r;

  // counters
  logic [CW-1:0] col_r, col_nxt;
  logic [15:0]   row_r, row_nxt;
  logic [CW-1:0] drn_r, drn_nxt;

  // line memory: [15:8] older row, [7:0] newer row
  logic [15:0] line_mem [MAX_WIDTH];
  logic [15:0] rd_q_r;
  logic        fwd_r;
  logic [15:0] fwd_data_r;

  // pipeline
  logic        s1_valid_r, s1_valid_nxt;
  s1_t         s1_r, s1_nxt;
  logic        s2_valid_r;
  emit_t       s2_r;
  logic        s3_valid_r;
  emit_t       s3_r;
  logic [7:0]  win_r [3][3];
  logic signed [16:0] prod_a_r [3][3];
  logic signed [16:0] prod_b_r [3][3];

  // output queue
  c3x3_pkg::out_item_t q_mem_r [c3x3_pkg::OUT_DEPTH];
  logic [QA-1:0] q_wr_r, q_rd_r;
  logic [QC-1:0] q_cnt_r;

  logic          in_acc, out_acc;
  logic [EW-1:0] eff_w;
  logic [15:0]   eff_h;
  logic [CW-1:0] cur_col;
  logic          last_col;
  logic [15:0] rd_word, wr_word;
  logic [7:0]  top_px, mid_px, bot_px;
  logic signed [7:0]  coef [3][3];
  logic signed [16:0] prod_a [3][3];
  logic signed [16:0] prod_b [3][3];
  logic signed [20:0] sum_a, sum_b;
  c3x3_pkg::out_item_t res_a, res_b;
  logic [1:0]    push_n;
  logic [1:0]    in_flight;
  logic [OW-1:0] occupancy;

  function automatic logic [7:0] clamp_sum(input logic signed [20:0] s);
    logic signed [20:0] q;
    q = s >>> c3x3_pkg::SUM_SHIFT;
    if (s < 0) begin
      return 8'd0;
    end else if (q > 21'(c3x3_pkg::PIX_MAX)) begin
      return 8'(c3x3_pkg::PIX_MAX);
    end else begin
      return q[7:0];
    end
  endfunction

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r[0] <= '0;
      mask_r[1] <= '0;
      mask_r[2] <= '0;
      width_r   <= 12'd2048;
      height_r  <= 16'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        c3x3_pkg::CFG_MASK_TOP:    mask_r[0] <= cfg_data;
        c3x3_pkg::CFG_MASK_MIDDLE: mask_r[1] <= cfg_data;
        c3x3_pkg::CFG_MASK_BOTTOM: mask_r[2] <= cfg_data;
        c3x3_pkg::CFG_WIDTH:       width_r   <= cfg_data[11:0];
        c3x3_pkg::CFG_HEIGHT:      height_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // effective geometry
  always_comb begin
    if (width_r == 12'd0) begin
      eff_w = EW'(1);
    end else if (EW'(width_r) > EW'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(width_r);
    end
    eff_h = (height_r == 16'd0) ? 16'd1 : height_r;
  end

  // input acceptance and occupancy reservation
  assign in_flight = 2'(s1_valid_r) + 2'(s2_valid_r) + 2'(s3_valid_r);
  assign occupancy = OW'(q_cnt_r) + OW'({in_flight, 1'b0});
  assign in_ready  = occupancy <= OW'(c3x3_pkg::OUT_DEPTH - 2);
  assign in_acc    = in_valid && in_ready;

  // counters and stage 1 control
  always_comb begin
    col_nxt      = col_r;
    row_nxt      = row_r;
    drn_nxt      = drn_r;
    s1_valid_nxt = 1'b0;
    s1_nxt       = '0;
    cur_col      = (in_data.func == c3x3_pkg::FUNC_DRAIN) ? drn_r : col_r;
    last_col     = (EW'(cur_col) + EW'(1)) >= eff_w;
    s1_nxt.addr  = cur_col;
    s1_nxt.pixel = in_data.pixel;
    s1_nxt.first = cur_col == '0;
    if (in_acc) begin
      if (in_data.func == c3x3_pkg::FUNC_PIXEL) begin
        if (row_r < eff_h) begin
          s1_valid_nxt     = 1'b1;
          s1_nxt.wr        = 1'b1;
          s1_nxt.has_row   = row_r >= 16'd1;
          s1_nxt.use_older = row_r >= 16'd2;
          s1_nxt.emit_l    = (row_r >= 16'd1) && (cur_col != '0);
          s1_nxt.emit_r    = (row_r >= 16'd1) && last_col;
          if (last_col) begin
            col_nxt = '0;
            row_nxt = (row_r == 16'hFFFF) ? 16'hFFFF : row_r + 16'd1;
          end else begin
            col_nxt = col_r + CW'(1);
          end
        end
      end else begin
        if (row_r >= eff_h) begin
          s1_valid_nxt     = 1'b1;
          s1_nxt.drain     = 1'b1;
          s1_nxt.has_row   = 1'b1;
          s1_nxt.use_older = eff_h >= 16'd2;
          s1_nxt.last_row  = 1'b1;
          s1_nxt.emit_l    = cur_col != '0;
          s1_nxt.emit_r    = last_col;
          if (last_col) begin
            drn_nxt = '0;
            col_nxt = '0;
            row_nxt = '0;
          end else begin
            drn_nxt = drn_r + CW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      drn_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      drn_r      <= drn_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
  end

  // stage 1: line memory data with bypass of the write in the same cycle
  assign rd_word = fwd_r ? fwd_data_r : rd_q_r;
  assign mid_px  = rd_word[7:0];
  assign top_px  = s1_r.use_older ? rd_word[15:8] : mid_px;
  assign bot_px  = s1_r.drain ? mid_px : s1_r.pixel;
  assign wr_word = {rd_word[7:0], s1_r.pixel};

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_r.wr) begin
      line_mem[s1_r.addr] <= wr_word;
    end
    if (in_acc) begin
      rd_q_r <= line_mem[cur_col];
    end
    fwd_r      <= s1_valid_r && s1_r.wr && (s1_r.addr == cur_col);
    fwd_data_r <= wr_word;
  end

  // window update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          win_r[r][k] <= '0;
        end
      end
    end else if (s1_valid_r && s1_r.has_row) begin
      if (s1_r.first) begin
        win_r[0][0] <= top_px;
        win_r[0][1] <= top_px;
        win_r[1][0] <= mid_px;
        win_r[1][1] <= mid_px;
        win_r[2][0] <= bot_px;
        win_r[2][1] <= bot_px;
      end else begin
        for (int r = 0; r < 3; r++) begin
          win_r[r][0] <= win_r[r][1];
          win_r[r][1] <= win_r[r][2];
        end
      end
      win_r[0][2] <= top_px;
      win_r[1][2] <= mid_px;
      win_r[2][2] <= bot_px;
    end
  end

  // stage 2: products for the inner and the right-edge window
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        coef[r][k]   = $signed(mask_r[r][8*k +: 8]);
        prod_a[r][k] = 17'($signed({1'b0, win_r[r][k]})) * 17'(coef[r][k]);
        prod_b[r][k] = 17'($signed({1'b0, win_r[r][(k == 0) ? 1 : 2]})) *
                       17'(coef[r][k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        prod_a_r[r][k] <= prod_a[r][k];
        prod_b_r[r][k] <= prod_b[r][k];
      end
    end
    s2_r.emit_l   <= s1_r.emit_l;
    s2_r.emit_r   <= s1_r.emit_r;
    s2_r.last_row <= s1_r.last_row;
    s3_r          <= s2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  // stage 3: sums, shift and clamp
  always_comb begin
    sum_a = '0;
    sum_b = '0;
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        sum_a = sum_a + 21'(prod_a_r[r][k]);
        sum_b = sum_b + 21'(prod_b_r[r][k]);
      end
    end
    res_a.value        = clamp_sum(sum_a);
    res_a.end_of_row   = 1'b0;
    res_a.end_of_frame = 1'b0;
    res_b.value        = clamp_sum(sum_b);
    res_b.end_of_row   = 1'b1;
    res_b.end_of_frame = s3_r.last_row;
    push_n = s3_valid_r ? (2'(s3_r.emit_l) + 2'(s3_r.emit_r)) : 2'd0;
  end

  // output queue
  assign out_valid = q_cnt_r != '0;
  assign out_data  = q_mem_r[q_rd_r];
  assign out_acc   = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (s3_valid_r && s3_r.emit_l) begin
      q_mem_r[q_wr_r] <= res_a;
    end
    if (s3_valid_r && s3_r.emit_r) begin
      q_mem_r[q_wr_r + QA'(s3_r.emit_l)] <= res_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wr_r  <= '0;
      q_rd_r  <= '0;
      q_cnt_r <= '0;
    end else begin
      q_wr_r  <= q_wr_r + QA'(push_n);
      q_rd_r  <= q_rd_r + QA'(out_acc);
      q_cnt_r <= q_cnt_r + QC'(push_n) - QC'(out_acc);
    end
  end

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// testbench for conv3x3_clamped_u8: directed table, random frames and a line-buffer predictor
`timescale 1ns / 100ps

module tb;

  localparam int MAXW        = c3x3_pkg::MAX_WIDTH_DEF;
  localparam int RAND_ITEMS  = 700;
  localparam int DRAIN_WAIT  = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    bit                  on;
    bit                  has;
    c3x3_pkg::out_item_t res;
  } pin_t;

  typedef struct packed {
    bit                 is_cfg;
    c3x3_pkg::cfg_idx_t reg_idx;
    logic [23:0]        reg_val;
    c3x3_pkg::in_item_t item;
    pin_t               pin;
  } step_row_t;

  localparam pin_t PIN_OFF  = '0;
  localparam pin_t PIN_NONE = '{on: 1'b1, has: 1'b0, res: '0};

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  c3x3_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  c3x3_pkg::out_item_t out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  c3x3_pkg::cfg_idx_t  cfg_index = c3x3_pkg::CFG_MASK_TOP;
  logic [23:0]         cfg_data = '0;

  conv3x3_clamped_u8 dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // filter state mirrored from the block
  logic [23:0] mask_rows [3] = '{default: '0};
  logic [11:0] width_reg = 12'd2048;
  logic [15:0] height_reg = 16'd1;
  logic [7:0]  line_older [MAXW];
  logic [7:0]  line_newer [MAXW];
  logic [7:0]  win [9] = '{default: '0};
  int          col_cnt = 0;
  int          row_cnt = 0;
  int          drain_cnt = 0;

  c3x3_pkg::out_item_t step_pixels [$];
  c3x3_pkg::out_item_t expected_pixels [$];
  pin_t                pins [$];

  bit no_idle = 1'b0;
  bit hold_req = 1'b0;
  int n_items = 0;
  int n_results = 0;
  int n_fail = 0;
  int n_setups = 0;
  int real_items = 0;
  int quiet = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int eff_width(logic [11:0] v);
    if (v == 0) return 1;
    if (int'(v) > MAXW) return MAXW;
    return int'(v);
  endfunction

  function automatic int tap(int r, int k);
    logic [7:0] b;
    b = mask_rows[r][8*k +: 8];
    return int'($signed(b));
  endfunction

  function automatic logic [7:0] filt(int lft, int ctr, int rgt);
    int pos [3];
    int acc;
    pos = '{lft, ctr, rgt};
    acc = 0;
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        acc += int'(win[r*3 + pos[k]]) * tap(r, k);
      end
    end
    if (acc < 0) return 8'd0;
    acc = acc >>> c3x3_pkg::SUM_SHIFT;
    return (acc > c3x3_pkg::PIX_MAX) ? 8'(c3x3_pkg::PIX_MAX) : 8'(acc);
  endfunction

  function automatic void load_column(logic [7:0] top_px, logic [7:0] mid_px,
                                      logic [7:0] bot_px, bit row_start);
    logic [7:0] v [3];
    v = '{top_px, mid_px, bot_px};
    for (int r = 0; r < 3; r++) begin
      if (row_start) begin
        win[r*3]     = v[r];
        win[r*3 + 1] = v[r];
      end else begin
        win[r*3]     = win[r*3 + 1];
        win[r*3 + 1] = win[r*3 + 2];
      end
      win[r*3 + 2] = v[r];
    end
  endfunction

  function automatic void emit(int c, int w, bit last_row);
    c3x3_pkg::out_item_t r;
    if (c >= 1) begin
      r.value = filt(0, 1, 2);
      r.end_of_row = 1'b0;
      r.end_of_frame = 1'b0;
      step_pixels.push_back(r);
    end
    if (c + 1 >= w) begin
      r.value = filt(1, 2, 2);
      r.end_of_row = 1'b1;
      r.end_of_frame = last_row;
      step_pixels.push_back(r);
    end
  endfunction

  function automatic void convolve_item(c3x3_pkg::in_item_t it);
    int w;
    int h;
    int c;
    int d;
    logic [7:0] top_px;
    logic [7:0] mid_px;
    w = eff_width(width_reg);
    h = (height_reg == 0) ? 1 : int'(height_reg);
    step_pixels.delete();
    if (it.func == c3x3_pkg::FUNC_PIXEL) begin
      if (row_cnt >= h) return;
      c = col_cnt;
      if (row_cnt >= 1) begin
        mid_px = line_newer[c];
        top_px = (row_cnt >= 2) ? line_older[c] : mid_px;
        load_column(top_px, mid_px, it.pixel, c == 0);
        emit(c, w, 1'b0);
      end
      line_older[c] = line_newer[c];
      line_newer[c] = it.pixel;
      if (c + 1 >= w) begin
        col_cnt = 0;
        row_cnt = (row_cnt >= 16'hFFFF) ? 16'hFFFF : row_cnt + 1;
      end else begin
        col_cnt = c + 1;
      end
    end else begin
      if (row_cnt < h) return;
      d = drain_cnt;
      mid_px = line_newer[d];
      top_px = (h >= 2) ? line_older[d] : mid_px;
      load_column(top_px, mid_px, mid_px, d == 0);
      emit(d, w, 1'b1);
      if (d + 1 >= w) begin
        drain_cnt = 0;
        col_cnt = 0;
        row_cnt = 0;
      end else begin
        drain_cnt = d + 1;
      end
    end
  endfunction

  function automatic void accept_item(c3x3_pkg::in_item_t it);
    pin_t p;
    p = pins.pop_front();
    convolve_item(it);
    if (p.on) begin
      if (p.has) expected_pixels.push_back(p.res);
    end else begin
      foreach (step_pixels[k]) expected_pixels.push_back(step_pixels[k]);
    end
    n_items++;
  endfunction

  function automatic void accept_cfg(c3x3_pkg::cfg_idx_t idx, logic [23:0] val);
    case (idx)
      c3x3_pkg::CFG_MASK_TOP:    mask_rows[0] = val;
      c3x3_pkg::CFG_MASK_MIDDLE: mask_rows[1] = val;
      c3x3_pkg::CFG_MASK_BOTTOM: mask_rows[2] = val;
      c3x3_pkg::CFG_WIDTH:       width_reg = val[11:0];
      c3x3_pkg::CFG_HEIGHT:      height_reg = val[15:0];
      default: ;
    endcase
  endfunction

  function automatic void check_pixel(c3x3_pkg::out_item_t got);
    c3x3_pkg::out_item_t want;
    if (expected_pixels.size() == 0) begin
      $error("unexpected result: value %0d end_of_row %0d end_of_frame %0d",
             got.value, got.end_of_row, got.end_of_frame);
      n_fail++;
      return;
    end
    want = expected_pixels.pop_front();
    n_results++;
    if (got.value !== want.value) begin
      $error("value: expected %0d, got %0d", want.value, got.value);
      n_fail++;
    end
    if (got.end_of_row !== want.end_of_row) begin
      $error("end_of_row: expected %0d, got %0d", want.end_of_row, got.end_of_row);
      n_fail++;
    end
    if (got.end_of_frame !== want.end_of_frame) begin
      $error("end_of_frame: expected %0d, got %0d", want.end_of_frame, got.end_of_frame);
      n_fail++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) check_pixel(out_data);
      if (in_valid && in_ready) accept_item(in_data);
      if (cfg_valid && cfg_ready) accept_cfg(cfg_index, cfg_data);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("timeout: nothing moved for %0d cycles", STALL_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      out_ready <= no_idle || ($urandom_range(99) >= 33);
    end
  end

  task automatic send_item(c3x3_pkg::in_item_t it, pin_t pin);
    while (!no_idle && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    pins.push_back(pin);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic cfg_write(c3x3_pkg::cfg_idx_t idx, logic [23:0] val);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] rand_pixel();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] rand_mask();
    logic [23:0] m;
    for (int k = 0; k < 3; k++) begin
      case ($urandom_range(5)) inside
        0:       m[8*k +: 8] = 8'h7F;
        1:       m[8*k +: 8] = 8'h80;
        2:       m[8*k +: 8] = 8'h00;
        [3:4]:   m[8*k +: 8] = 8'($urandom_range(0, 15));
        default: m[8*k +: 8] = 8'($urandom);
      endcase
    end
    return m;
  endfunction

  task automatic setup(logic [11:0] wv, logic [15:0] hv);
    cfg_write(c3x3_pkg::CFG_MASK_TOP, rand_mask());
    cfg_write(c3x3_pkg::CFG_MASK_MIDDLE, rand_mask());
    cfg_write(c3x3_pkg::CFG_MASK_BOTTOM, rand_mask());
    cfg_write(c3x3_pkg::CFG_WIDTH, 24'(wv));
    cfg_write(c3x3_pkg::CFG_HEIGHT, 24'(hv));
    n_setups++;
  endtask

  // stray items the block must drop
  task automatic maybe_stray(logic func);
    if ($urandom_range(19) == 0) send_item('{func: func, pixel: rand_pixel()}, PIN_OFF);
  endtask

  task automatic run_frame(int w, int h, bit cut);
    int rows;
    logic [15:0] hv;
    rows = h;
    for (int r = 0; r < rows; r++) begin
      if (cut && r == 1) begin
        hv = 16'($urandom_range(0, 4));
        cfg_write(c3x3_pkg::CFG_HEIGHT, 24'(hv));
        rows = (hv == 0) ? 1 : int'(hv);
        if (rows <= 1) break;
      end
      for (int c = 0; c < w; c++) begin
        maybe_stray(c3x3_pkg::FUNC_DRAIN);
        send_item('{func: c3x3_pkg::FUNC_PIXEL, pixel: rand_pixel()}, PIN_OFF);
        real_items++;
      end
    end
    for (int d = 0; d < w; d++) begin
      maybe_stray(c3x3_pkg::FUNC_PIXEL);
      send_item('{func: c3x3_pkg::FUNC_DRAIN, pixel: rand_pixel()}, PIN_OFF);
      real_items++;
    end
  endtask

  function automatic step_row_t reg_row(c3x3_pkg::cfg_idx_t idx, logic [23:0] val);
    step_row_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.reg_idx = idx;
    s.reg_val = val;
    return s;
  endfunction

  function automatic step_row_t item_row(logic func, logic [7:0] px, pin_t pin);
    step_row_t s;
    s = '0;
    s.item.func = func;
    s.item.pixel = px;
    s.pin = pin;
    return s;
  endfunction

  function automatic pin_t pin_out(logic [7:0] val, logic eor, logic eof);
    pin_t p;
    p.on = 1'b1;
    p.has = 1'b1;
    p.res.value = val;
    p.res.end_of_row = eor;
    p.res.end_of_frame = eof;
    return p;
  endfunction

  initial begin : stimulus
    step_row_t directed_steps [$];
    logic [11:0] wv;
    logic [15:0] hv;

    directed_steps = '{
      item_row(c3x3_pkg::FUNC_DRAIN, 8'hA5, PIN_NONE),
      reg_row(c3x3_pkg::CFG_WIDTH, 24'd0),
      item_row(c3x3_pkg::FUNC_PIXEL, 8'hFF, PIN_NONE),
      item_row(c3x3_pkg::FUNC_PIXEL, 8'h00, PIN_NONE),
      item_row(c3x3_pkg::FUNC_DRAIN, 8'h3C, pin_out(8'd0, 1'b1, 1'b1)),
      reg_row(c3x3_pkg::CFG_MASK_TOP, 24'h7F7F7F),
      reg_row(c3x3_pkg::CFG_MASK_MIDDLE, 24'h7F7F7F),
      reg_row(c3x3_pkg::CFG_MASK_BOTTOM, 24'h7F7F7F),
      item_row(c3x3_pkg::FUNC_PIXEL, 8'hFF, PIN_NONE),
      item_row(c3x3_pkg::FUNC_DRAIN, 8'h00, pin_out(8'd255, 1'b1, 1'b1)),
      reg_row(c3x3_pkg::CFG_MASK_TOP, 24'h808080),
      reg_row(c3x3_pkg::CFG_MASK_MIDDLE, 24'h808080),
      reg_row(c3x3_pkg::CFG_MASK_BOTTOM, 24'h808080),
      reg_row(c3x3_pkg::CFG_HEIGHT, 24'd0),
      item_row(c3x3_pkg::FUNC_PIXEL, 8'hFF, PIN_NONE),
      item_row(c3x3_pkg::FUNC_DRAIN, 8'hFF, pin_out(8'd0, 1'b1, 1'b1)),
      reg_row(c3x3_pkg::CFG_MASK_TOP, 24'h01FE10),
      reg_row(c3x3_pkg::CFG_MASK_MIDDLE, 24'h20F00C),
      reg_row(c3x3_pkg::CFG_MASK_BOTTOM, 24'hFF0403),
      reg_row(c3x3_pkg::CFG_WIDTH, 24'd3),
      reg_row(c3x3_pkg::CFG_HEIGHT, 24'hFFFF),
      item_row(c3x3_pkg::FUNC_PIXEL, 8'h00, PIN_OFF),
      item_row(c3x3_pkg::FUNC_PIXEL, 8'hFF, PIN_OFF),
      item_row(c3x3_pkg::FUNC_PIXEL, 8'h11, PIN_OFF),
      item_row(c3x3_pkg::FUNC_PIXEL, 8'h80, PIN_OFF),
      item_row(c3x3_pkg::FUNC_PIXEL, 8'h40, PIN_OFF),
      item_row(c3x3_pkg::FUNC_PIXEL, 8'hC8, PIN_OFF),
      reg_row(c3x3_pkg::CFG_HEIGHT, 24'd2),
      item_row(c3x3_pkg::FUNC_DRAIN, 8'h5A, PIN_OFF),
      item_row(c3x3_pkg::FUNC_DRAIN, 8'h00, PIN_OFF),
      item_row(c3x3_pkg::FUNC_DRAIN, 8'hFF, PIN_OFF)
    };

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_steps[k]) begin
      if (directed_steps[k].is_cfg) begin
        cfg_write(directed_steps[k].reg_idx, directed_steps[k].reg_val);
      end else begin
        send_item(directed_steps[k].item, directed_steps[k].pin);
      end
    end

    while (real_items < RAND_ITEMS) begin
      no_idle = (n_setups >= 12 && n_setups < 20);
      case ($urandom_range(9))
        0:       wv = 12'd0;
        1:       wv = 12'd1;
        default: wv = 12'($urandom_range(2, 12));
      endcase
      case ($urandom_range(9))
        0:       hv = 16'd0;
        1:       hv = 16'd1;
        default: hv = 16'($urandom_range(2, 6));
      endcase
      setup(wv, hv);
      run_frame(eff_width(wv), (hv == 0) ? 1 : int'(hv), hv >= 2 && $urandom_range(4) == 0);
    end
    no_idle = 1'b0;

    // long output stall while the sender keeps offering items
    setup(12'd40, 16'd3);
    hold_req = 1'b1;
    run_frame(40, 3, 1'b0);

    wait_idle();
    $display("run covered %0d items and %0d filtered pixels over %0d frame setups,",
             n_items, n_results, n_setups);
    $display("including stray items, geometry extremes and a long receiver stall: %0d mismatches",
             n_fail);
    if (n_fail == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- conv3x3_clamped_u8.f -----
sv/c3x3_pkg.sv
sv/conv3x3_clamped_u8.sv
sim/tb.sv
